// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the detector's modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define TED_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ted_pkg.sv =====
package ted_pkg;

  // Encoding classes given for a whole file.
  typedef enum logic [2:0] {
    CLASS_UTF8     = 3'd0,
    CLASS_UTF8_BOM = 3'd1,
    CLASS_UTF16LE  = 3'd2,
    CLASS_UTF16BE  = 3'd3,
    CLASS_ANSI     = 3'd4
  } enc_class_t;

  // Allowed range of the next UTF-8 continuation byte.
  typedef enum logic [2:0] {
    RANGE_ANY   = 3'd0,
    RANGE_A0_BF = 3'd1,
    RANGE_80_9F = 3'd2,
    RANGE_90_BF = 3'd3,
    RANGE_80_8F = 3'd4
  } cont_range_t;

  // Byte order mark bytes.
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;

  // Per-file facts handed from the byte stage to the classifier.
  typedef struct packed {
    logic [23:0] leading_bytes;
    logic        length_odd;
    logic        utf8_invalid;
  } file_flags_t;

endpackage

// ===== hw/rtl/ted_byte_if.sv =====
interface ted_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source(output valid, output text_byte, output final_byte, input ready);
  modport sink(input valid, input text_byte, input final_byte, output ready);
endinterface

// ===== hw/rtl/ted_class_if.sv =====
interface ted_class_if;
  logic       valid;
  logic       ready;
  logic [2:0] encoding_class;

  modport source(output valid, output encoding_class, input ready);
  modport sink(input valid, input encoding_class, output ready);
endinterface

// ===== hw/rtl/ted_utf8.sv =====
`include "assert_macros.svh"

module ted_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output logic       invalid_final
);

  logic [1:0]           cont_left;
  logic [1:0]           cont_left_next;
  ted_pkg::cont_range_t cont_range;
  ted_pkg::cont_range_t cont_range_next;
  logic                 invalid;
  logic                 invalid_next;
  logic [7:0]           range_lo;
  logic [7:0]           range_hi;

  // Bounds of the continuation byte expected next.
  always_comb begin
    range_lo = 8'h80;
    range_hi = 8'hBF;
    case (cont_range)
      ted_pkg::RANGE_A0_BF: range_lo = 8'hA0;
      ted_pkg::RANGE_80_9F: range_hi = 8'h9F;
      ted_pkg::RANGE_90_BF: range_lo = 8'h90;
      ted_pkg::RANGE_80_8F: range_hi = 8'h8F;
      default: ;
    endcase
  end

  // Validator step for one byte; an invalid file stays invalid.
  always_comb begin
    cont_left_next  = cont_left;
    cont_range_next = cont_range;
    invalid_next    = invalid;
    if (!invalid) begin
      if (cont_left != 2'd0) begin
        if (text_byte < range_lo || text_byte > range_hi) begin
          invalid_next = 1'b1;
        end else begin
          cont_left_next  = cont_left - 2'd1;
          cont_range_next = ted_pkg::RANGE_ANY;
        end
      end else begin
        cont_range_next = ted_pkg::RANGE_ANY;
        case (text_byte) inside
          [8'h00:8'h7F]: ;
          [8'hC2:8'hDF]: cont_left_next = 2'd1;
          [8'hE0:8'hEF]: begin
            cont_left_next = 2'd2;
            if (text_byte == 8'hE0) cont_range_next = ted_pkg::RANGE_A0_BF;
            else if (text_byte == 8'hED) cont_range_next = ted_pkg::RANGE_80_9F;
          end
          [8'hF0:8'hF4]: begin
            cont_left_next = 2'd3;
            if (text_byte == 8'hF0) cont_range_next = ted_pkg::RANGE_90_BF;
            else if (text_byte == 8'hF4) cont_range_next = ted_pkg::RANGE_80_8F;
          end
          default: invalid_next = 1'b1;
        endcase
      end
    end
  end

  // A sequence cut off by the end of the file also makes it invalid.
  assign invalid_final = invalid_next | (cont_left_next != 2'd0);

  // Validator state; cleared after the last byte of each file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cont_left  <= 2'd0;
      cont_range <= ted_pkg::RANGE_ANY;
      invalid    <= 1'b0;
    end else if (step) begin
      if (final_byte) begin
        cont_left  <= 2'd0;
        cont_range <= ted_pkg::RANGE_ANY;
        invalid    <= 1'b0;
      end else begin
        cont_left  <= cont_left_next;
        cont_range <= cont_range_next;
        invalid    <= invalid_next;
      end
    end
  end

  // A narrowed range only exists while continuation bytes are expected.
  `TED_ASSERT_NEVER(a_range_without_cont,
    cont_range != ted_pkg::RANGE_ANY && cont_left == 2'd0,
    "continuation range set with no continuation pending")

endmodule

// ===== hw/rtl/ted_stats.sv =====
`include "assert_macros.svh"

module ted_stats #(
  parameter int SAMPLE_LOG2 = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             text_byte,
  input  logic                   final_byte,
  output logic [SAMPLE_LOG2:0]   n_final,
  output logic [SAMPLE_LOG2-1:0] nul_even_final,
  output logic [SAMPLE_LOG2-1:0] nul_odd_final,
  output logic                   length_odd_final,
  output logic [23:0]            leading_final
);

  localparam int PosW = SAMPLE_LOG2 + 1;
  localparam int CntW = SAMPLE_LOG2;

  logic [PosW-1:0] byte_position;
  logic [PosW-1:0] byte_position_next;
  logic            length_odd;
  logic [23:0]     leading_bytes;
  logic [23:0]     leading_bytes_next;
  logic [CntW-1:0] nul_even_count;
  logic [CntW-1:0] nul_even_count_next;
  logic [CntW-1:0] nul_odd_count;
  logic [CntW-1:0] nul_odd_count_next;
  logic            in_sample;

  // The position saturates at the sample limit, which is its top bit alone.
  assign in_sample = ~byte_position[PosW-1];

  // Counter and capture updates for one byte.
  always_comb begin
    leading_bytes_next  = leading_bytes;
    nul_even_count_next = nul_even_count;
    nul_odd_count_next  = nul_odd_count;
    if (byte_position == PosW'(0)) leading_bytes_next[7:0]   = text_byte;
    if (byte_position == PosW'(1)) leading_bytes_next[15:8]  = text_byte;
    if (byte_position == PosW'(2)) leading_bytes_next[23:16] = text_byte;
    if (in_sample && text_byte == 8'h00) begin
      if (length_odd) nul_odd_count_next  = nul_odd_count + CntW'(1);
      else            nul_even_count_next = nul_even_count + CntW'(1);
    end
    byte_position_next = in_sample ? byte_position + PosW'(1) : byte_position;
  end

  assign n_final          = byte_position_next;
  assign nul_even_final   = nul_even_count_next;
  assign nul_odd_final    = nul_odd_count_next;
  assign length_odd_final = ~length_odd;
  assign leading_final    = leading_bytes_next;

  // File statistics; cleared after the last byte of each file.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      length_odd     <= 1'b0;
      leading_bytes  <= '0;
      nul_even_count <= '0;
      nul_odd_count  <= '0;
    end else if (step) begin
      if (final_byte) begin
        byte_position  <= '0;
        length_odd     <= 1'b0;
        leading_bytes  <= '0;
        nul_even_count <= '0;
        nul_odd_count  <= '0;
      end else begin
        byte_position  <= byte_position_next;
        length_odd     <= ~length_odd;
        leading_bytes  <= leading_bytes_next;
        nul_even_count <= nul_even_count_next;
        nul_odd_count  <= nul_odd_count_next;
      end
    end
  end

  // NUL bytes are only counted inside the sample, so never more than the position.
  `TED_ASSERT(a_nul_within_position,
    ({1'b0, nul_even_count} + {1'b0, nul_odd_count}) <= byte_position,
    "NUL counts exceed bytes seen")

  // The last byte of a file leaves the counters clear for the next one.
  `TED_ASSERT(a_clear_after_final,
    step && final_byte |=> byte_position == PosW'(0) && !length_odd,
    "statistics not cleared after the last byte")

endmodule

// ===== hw/rtl/ted_classify.sv =====
module ted_classify #(
  parameter int SAMPLE_LOG2 = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   snap_valid,
  output logic                   snap_ready,
  input  logic [SAMPLE_LOG2:0]   n,
  input  logic [SAMPLE_LOG2-1:0] nul_even,
  input  logic [SAMPLE_LOG2-1:0] nul_odd,
  input  ted_pkg::file_flags_t   flags,
  ted_class_if.source            class_out
);

  localparam int PosW = SAMPLE_LOG2 + 1;

  logic [PosW-1:0]     quarter;
  logic [PosW-1:0]     even_ext;
  logic [PosW-1:0]     odd_ext;
  logic [PosW-1:0]     even_twice;
  logic [PosW-1:0]     odd_twice;
  logic [7:0]          b0;
  logic [7:0]          b1;
  logic [7:0]          b2;
  logic                n_ge2;
  logic                n_ge3;
  logic                n_ge4;
  logic                utf16_ok;
  ted_pkg::enc_class_t cls;
  logic                out_valid;
  ted_pkg::enc_class_t out_class;

  assign b0 = flags.leading_bytes[7:0];
  assign b1 = flags.leading_bytes[15:8];
  assign b2 = flags.leading_bytes[23:16];

  assign n_ge2 = |n[PosW-1:1];
  assign n_ge4 = |n[PosW-1:2];
  assign n_ge3 = n_ge4 | (n[1:0] == 2'b11);

  // NUL-count ratios for the markless UTF-16 test.
  assign quarter    = n >> 2;
  assign even_ext   = {1'b0, nul_even};
  assign odd_ext    = {1'b0, nul_odd};
  assign even_twice = {nul_even, 1'b0};
  assign odd_twice  = {nul_odd, 1'b0};
  assign utf16_ok   = n_ge4 && !flags.length_odd;

  // Rules in priority order: marks, then NUL pattern, then UTF-8 validity.
  always_comb begin
    if (n_ge3 && b0 == ted_pkg::BOM_EF && b1 == ted_pkg::BOM_BB && b2 == ted_pkg::BOM_BF)
      cls = ted_pkg::CLASS_UTF8_BOM;
    else if (n_ge2 && b0 == ted_pkg::BOM_FF && b1 == ted_pkg::BOM_FE)
      cls = ted_pkg::CLASS_UTF16LE;
    else if (n_ge2 && b0 == ted_pkg::BOM_FE && b1 == ted_pkg::BOM_FF)
      cls = ted_pkg::CLASS_UTF16BE;
    else if (utf16_ok && odd_ext >= quarter && odd_ext > even_twice)
      cls = ted_pkg::CLASS_UTF16LE;
    else if (utf16_ok && even_ext >= quarter && even_ext > odd_twice)
      cls = ted_pkg::CLASS_UTF16BE;
    else if (!flags.utf8_invalid)
      cls = ted_pkg::CLASS_UTF8;
    else
      cls = ted_pkg::CLASS_ANSI;
  end

  // Result register; it takes a new snapshot whenever it is empty or being read.
  assign snap_ready = !out_valid || class_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      out_class <= cls;
    end
  end

  assign class_out.valid          = out_valid;
  assign class_out.encoding_class = out_class;

endmodule

// ===== hw/rtl/text_encoding_detector.sv =====
// Text encoding detector: one byte is accepted per cycle, back to back, unless
// a finished file is stuck in the snapshot register. Each byte updates the
// counters and the UTF-8 validator. After the last byte of a file is accepted,
// its facts go to the snapshot register and its class to the result register;
// the next file may start at once. Synchronous active-high reset clears all
// per-file state and empties the pipeline; no clearing pass is needed.
`include "assert_macros.svh"

module text_encoding_detector #(
  parameter int SAMPLE_LOG2 = 20
) (
  input  logic         clk,
  input  logic         rst,
  ted_byte_if.sink     byte_in,
  ted_class_if.source  class_out
);

  localparam int PosW = SAMPLE_LOG2 + 1;
  localparam int CntW = SAMPLE_LOG2;

  logic                 accept;
  logic                 snap_ready;
  logic                 snap_valid;
  logic [PosW-1:0]      n_final;
  logic [CntW-1:0]      nul_even_final;
  logic [CntW-1:0]      nul_odd_final;
  logic                 length_odd_final;
  logic [23:0]          leading_final;
  logic                 invalid_final;
  logic [PosW-1:0]      snap_n;
  logic [CntW-1:0]      snap_even;
  logic [CntW-1:0]      snap_odd;
  ted_pkg::file_flags_t snap_flags;

  // A byte can enter unless a finished file is stuck in the snapshot register.
  assign byte_in.ready = !snap_valid || snap_ready;
  assign accept        = byte_in.valid && byte_in.ready;

  ted_stats #(
    .SAMPLE_LOG2(SAMPLE_LOG2)
  ) u_stats (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .text_byte        (byte_in.text_byte),
    .final_byte       (byte_in.final_byte),
    .n_final          (n_final),
    .nul_even_final   (nul_even_final),
    .nul_odd_final    (nul_odd_final),
    .length_odd_final (length_odd_final),
    .leading_final    (leading_final)
  );

  ted_utf8 u_utf8 (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .text_byte     (byte_in.text_byte),
    .final_byte    (byte_in.final_byte),
    .invalid_final (invalid_final)
  );

  // Snapshot of a finished file's statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && byte_in.final_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_in.final_byte) begin
      snap_n                   <= n_final;
      snap_even                <= nul_even_final;
      snap_odd                 <= nul_odd_final;
      snap_flags.leading_bytes <= leading_final;
      snap_flags.length_odd    <= length_odd_final;
      snap_flags.utf8_invalid  <= invalid_final;
    end
  end

  ted_classify #(
    .SAMPLE_LOG2(SAMPLE_LOG2)
  ) u_classify (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .n          (snap_n),
    .nul_even   (snap_even),
    .nul_odd    (snap_odd),
    .flags      (snap_flags),
    .class_out  (class_out)
  );

  // Every last byte of a file produces a pending snapshot.
  `TED_ASSERT(a_final_makes_snapshot,
    accept && byte_in.final_byte |=> snap_valid,
    "last byte accepted without a snapshot")

  // A snapshot always covers at least one byte.
  `TED_ASSERT_NEVER(a_empty_snapshot,
    snap_valid && snap_n == PosW'(0),
    "snapshot holds a file of no bytes")

endmodule

// ===== tb/sv/text_encoding_detector_tb.sv =====
`timescale 1ns / 100ps

module text_encoding_detector_tb;
  import ted_pkg::*;

  // A small sample window so that long files run past it within a short test.
  localparam int SAMPLE_BITS  = 4;
  localparam int SAMPLE_SIZE  = 1 << SAMPLE_BITS;
  localparam int RANDOM_BYTES = 1700;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_FILES   = 60;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       typed;
    enc_class_t cls;
  } stim_row_t;

  // Directed files. Where typed is set, the class on the last item is the one written here.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{BOM_EF, 1'b0, 1'b0, CLASS_UTF8},
    '{BOM_BB, 1'b0, 1'b0, CLASS_UTF8},
    '{BOM_BF, 1'b1, 1'b1, CLASS_UTF8_BOM},
    '{BOM_FF, 1'b0, 1'b0, CLASS_UTF8},
    '{BOM_FE, 1'b1, 1'b1, CLASS_UTF16LE},
    '{BOM_FE, 1'b0, 1'b0, CLASS_UTF8},
    '{BOM_FF, 1'b1, 1'b1, CLASS_UTF16BE},
    '{8'h00,  1'b1, 1'b1, CLASS_UTF8},
    '{8'hFF,  1'b1, 1'b1, CLASS_ANSI},
    '{8'h41,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h00,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h42,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h00,  1'b1, 1'b1, CLASS_UTF16LE},
    '{8'h00,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h41,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h00,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h42,  1'b1, 1'b1, CLASS_UTF16BE},
    '{8'hC0,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h80,  1'b1, 1'b1, CLASS_ANSI},
    '{8'hE0,  1'b1, 1'b1, CLASS_ANSI},
    '{8'hED,  1'b0, 1'b0, CLASS_UTF8},
    '{8'hA0,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h80,  1'b1, 1'b0, CLASS_UTF8},
    '{8'hF4,  1'b0, 1'b0, CLASS_UTF8},
    '{8'h90,  1'b1, 1'b0, CLASS_UTF8}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_req = 1'b0;

  ted_byte_if  byte_bus ();
  ted_class_if class_bus ();

  text_encoding_detector #(
    .SAMPLE_LOG2(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_bus),
    .class_out(class_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Per-file state of the class predictor.
  logic [SAMPLE_BITS:0] seen_count;
  logic                 seen_odd;
  logic [7:0]           lead_bytes [3];
  logic [SAMPLE_BITS:0] nul_even;
  logic [SAMPLE_BITS:0] nul_odd;
  logic [1:0]           utf8_pending;
  cont_range_t          utf8_range;
  logic                 utf8_bad;

  enc_class_t  expected_classes [$];
  logic [7:0]  file_bytes [$];
  int unsigned burst_left;
  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned results_checked;
  int unsigned failures;
  int unsigned class_seen [5];

  task automatic clear_file_state();
    seen_count   = '0;
    seen_odd     = 1'b0;
    lead_bytes   = '{8'h00, 8'h00, 8'h00};
    nul_even     = '0;
    nul_odd      = '0;
    utf8_pending = 2'd0;
    utf8_range   = RANGE_ANY;
    utf8_bad     = 1'b0;
  endtask

  // Folds one byte into the file state; on the last byte gives the file's class.
  task automatic predict_encoding(input logic [7:0] b, input logic last,
                                  output logic done, output enc_class_t cls);
    logic [7:0] lo;
    logic [7:0] hi;
    done = 1'b0;
    cls  = CLASS_UTF8;
    if (seen_count < 3) lead_bytes[seen_count[1:0]] = b;
    if (seen_count < SAMPLE_SIZE && b == 8'h00) begin
      if (seen_odd) nul_odd++;
      else nul_even++;
    end

    // Strict UTF-8 validation; once broken the file stays broken.
    if (!utf8_bad) begin
      if (utf8_pending != 2'd0) begin
        lo = 8'h80;
        hi = 8'hBF;
        case (utf8_range)
          RANGE_A0_BF: lo = 8'hA0;
          RANGE_80_9F: hi = 8'h9F;
          RANGE_90_BF: lo = 8'h90;
          RANGE_80_8F: hi = 8'h8F;
          default: ;
        endcase
        if (b < lo || b > hi) begin
          utf8_bad = 1'b1;
        end else begin
          utf8_pending--;
          utf8_range = RANGE_ANY;
        end
      end else begin
        utf8_range = RANGE_ANY;
        if (b >= 8'hC2 && b <= 8'hDF) begin
          utf8_pending = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          utf8_pending = 2'd2;
          if (b == 8'hE0) utf8_range = RANGE_A0_BF;
          else if (b == 8'hED) utf8_range = RANGE_80_9F;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          utf8_pending = 2'd3;
          if (b == 8'hF0) utf8_range = RANGE_90_BF;
          else if (b == 8'hF4) utf8_range = RANGE_80_8F;
        end else if (b >= 8'h80) begin
          utf8_bad = 1'b1;
        end
      end
    end

    seen_odd = ~seen_odd;
    if (seen_count < SAMPLE_SIZE) seen_count++;

    // Classify in priority order: marks, unmarked UTF-16, then UTF-8 validity.
    if (last) begin
      done = 1'b1;
      if (utf8_pending != 2'd0) utf8_bad = 1'b1;
      if (seen_count >= 3 && lead_bytes[0] == BOM_EF && lead_bytes[1] == BOM_BB &&
          lead_bytes[2] == BOM_BF) begin
        cls = CLASS_UTF8_BOM;
      end else if (seen_count >= 2 && lead_bytes[0] == BOM_FF && lead_bytes[1] == BOM_FE) begin
        cls = CLASS_UTF16LE;
      end else if (seen_count >= 2 && lead_bytes[0] == BOM_FE && lead_bytes[1] == BOM_FF) begin
        cls = CLASS_UTF16BE;
      end else if (seen_count >= 4 && !seen_odd && nul_odd >= seen_count / 4 &&
                   nul_odd > 2 * nul_even) begin
        cls = CLASS_UTF16LE;
      end else if (seen_count >= 4 && !seen_odd && nul_even >= seen_count / 4 &&
                   nul_even > 2 * nul_odd) begin
        cls = CLASS_UTF16BE;
      end else if (!utf8_bad) begin
        cls = CLASS_UTF8;
      end else begin
        cls = CLASS_ANSI;
      end
      clear_file_state();
    end
  endtask

  // Offers one item, idling between bursts, and records the class it will cause.
  task automatic send_byte(input logic [7:0] value, input logic last,
                           input logic typed, input enc_class_t typed_cls);
    int unsigned gap;
    logic        done;
    enc_class_t  cls;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        byte_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    byte_bus.valid      <= 1'b1;
    byte_bus.text_byte  <= value;
    byte_bus.final_byte <= last;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    predict_encoding(value, last, done, cls);
    bytes_sent++;
    if (done) begin
      files_sent++;
      expected_classes = {expected_classes, typed ? typed_cls : cls};
    end
  endtask

  // Appends one byte to the file being built.
  task automatic append_byte(input logic [7:0] b);
    file_bytes = {file_bytes, b};
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, CLASS_UTF8);
    end
  endtask

  // Picks a scalar value, often at the edge of its encoded length class.
  function automatic int unsigned random_code_point(input logic multi);
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(multi ? 1 : 0, 4))
      0: begin lo = 'h0; hi = 'h7F; end
      1: begin lo = 'h80; hi = 'h7FF; end
      2: begin lo = 'h800; hi = 'hD7FF; end
      3: begin lo = 'hE000; hi = 'hFFFF; end
      default: begin lo = 'h10000; hi = 'h10FFFF; end
    endcase
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? hi : lo;
    return $urandom_range(lo, hi);
  endfunction

  task automatic add_code_point(input int unsigned cp);
    if (cp < 'h80) begin
      append_byte(8'(cp));
    end else if (cp < 'h800) begin
      append_byte(8'('hC0 | (cp >> 6)));
      append_byte(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      append_byte(8'('hE0 | (cp >> 12)));
      append_byte(8'('h80 | ((cp >> 6) & 'h3F)));
      append_byte(8'('h80 | (cp & 'h3F)));
    end else begin
      append_byte(8'('hF0 | (cp >> 18)));
      append_byte(8'('h80 | ((cp >> 12) & 'h3F)));
      append_byte(8'('h80 | ((cp >> 6) & 'h3F)));
      append_byte(8'('h80 | (cp & 'h3F)));
    end
  endtask

  // Builds one random file; most are well formed, the rest broken or plain noise.
  task automatic build_random_file();
    int unsigned kind;
    int unsigned pick;
    int unsigned count;
    int unsigned p_even;
    int unsigned p_odd;
    int unsigned cut;
    logic        le;
    logic [15:0] unit;
    logic [7:0]  mark [3];
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // Well-formed UTF-8, sometimes behind its mark.
      if ($urandom_range(0, 3) == 0) begin
        append_byte(BOM_EF);
        append_byte(BOM_BB);
        append_byte(BOM_BF);
      end
      repeat ($urandom_range(1, 12)) add_code_point(random_code_point(1'b0));
    end else if (kind < 45) begin
      // UTF-16 text in either byte order, with an optional mark or stray odd byte.
      le = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        append_byte(le ? BOM_FF : BOM_FE);
        append_byte(le ? BOM_FE : BOM_FF);
      end
      repeat ($urandom_range(1, 20)) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) unit = 16'($urandom_range('h20, 'h7E));
        else if (pick < 18) unit = 16'($urandom_range('h100, 'hFFFF));
        else unit = 16'($urandom_range(0, 'hFFFF));
        if (le) begin
          append_byte(unit[7:0]);
          append_byte(unit[15:8]);
        end else begin
          append_byte(unit[15:8]);
          append_byte(unit[7:0]);
        end
      end
      if ($urandom_range(0, 5) == 0) append_byte(8'($urandom_range(0, 255)));
    end else if (kind < 60) begin
      // Valid text around one broken spot.
      repeat ($urandom_range(0, 5)) add_code_point(random_code_point(1'b0));
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        case ($urandom_range(0, 8))
          0: begin
            append_byte(8'hC0);
            append_byte(8'($urandom_range('h80, 'hBF)));
          end
          1: begin
            append_byte(8'hC1);
            append_byte(8'($urandom_range('h80, 'hBF)));
          end
          2: begin
            append_byte(8'hE0);
            append_byte(8'($urandom_range('h80, 'h9F)));
            append_byte(8'h80);
          end
          3: begin
            append_byte(8'hED);
            append_byte(8'($urandom_range('hA0, 'hBF)));
            append_byte(8'h80);
          end
          4: begin
            append_byte(8'hF0);
            append_byte(8'($urandom_range('h80, 'h8F)));
            append_byte(8'h80);
            append_byte(8'h80);
          end
          5: begin
            append_byte(8'hF4);
            append_byte(8'($urandom_range('h90, 'hBF)));
            append_byte(8'h80);
            append_byte(8'h80);
          end
          6: append_byte(8'($urandom_range('hF5, 'hFF)));
          7: append_byte(8'($urandom_range('h80, 'hBF)));
          default: begin
            append_byte(8'($urandom_range('hC2, 'hF4)));
            append_byte(8'h41);
          end
        endcase
      end else if (pick == 1) begin
        if (file_bytes.size() == 0) append_byte(8'($urandom_range(0, 255)));
        else file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
        // A multi-byte sequence cut off by the end of the file.
        add_code_point(random_code_point(1'b1));
        void'(file_bytes.pop_back());
      end
      if (pick != 2) repeat ($urandom_range(0, 4)) add_code_point(random_code_point(1'b0));
    end else if (kind < 70) begin
      // A mark, possibly cut short, with a little text behind it.
      pick = $urandom_range(0, 2);
      case (pick)
        0: begin mark = '{BOM_EF, BOM_BB, BOM_BF}; count = 3; end
        1: begin mark = '{BOM_FF, BOM_FE, 8'h00}; count = 2; end
        default: begin mark = '{BOM_FE, BOM_FF, 8'h00}; count = 2; end
      endcase
      cut = $urandom_range(1, count);
      for (int i = 0; i < cut; i++) append_byte(mark[i]);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 1) != 0) append_byte(8'($urandom_range('h20, 'h7E)));
        else append_byte(8'($urandom_range(0, 255)));
      end
    end else if (kind < 80) begin
      // NUL-rich bytes with separate odds at even and odd positions.
      p_even = $urandom_range(0, 100);
      p_odd  = $urandom_range(0, 100);
      count  = $urandom_range(1, 2 * SAMPLE_SIZE + 8);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 99) < ((i % 2 != 0) ? p_odd : p_even)) append_byte(8'h00);
        else append_byte(8'($urandom_range(1, 255)));
      end
    end else if (kind < 90) begin
      // Plain text nearly filling the sample window, then NULs mixed with text.
      repeat (SAMPLE_SIZE - $urandom_range(0, 2)) begin
        append_byte(8'($urandom_range('h20, 'h7E)));
      end
      repeat ($urandom_range(1, 2 * SAMPLE_SIZE)) begin
        if ($urandom_range(0, 1) != 0) append_byte(8'h00);
        else append_byte(8'($urandom_range('h20, 'h7E)));
      end
    end else begin
      // Raw noise.
      repeat ($urandom_range(1, 24)) append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: switches between stall patterns, with one long hold-off on request.
  initial begin : receiver
    int unsigned cyc;
    int unsigned hold_left;
    logic        hold_done;
    int unsigned mode;
    class_bus.ready = 1'b0;
    cyc       = 0;
    hold_left = 0;
    hold_done = 1'b0;
    mode      = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        class_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: class_bus.ready <= 1'b1;
          1: class_bus.ready <= 1'($urandom_range(0, 1));
          2: class_bus.ready <= (cyc % 7) >= 3;
          default: class_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Each accepted result is matched against the oldest predicted class.
  always @(posedge clk) begin : check_results
    enc_class_t want;
    if (!rst && class_bus.valid && class_bus.ready) begin
      if (expected_classes.size() == 0) begin
        $error("encoding_class: no result expected, actual %0d", class_bus.encoding_class);
        failures++;
      end else begin
        want = expected_classes.pop_front();
        results_checked++;
        class_seen[want]++;
        if (class_bus.encoding_class !== want) begin
          $error("encoding_class: expected %0d, actual %0d", want, class_bus.encoding_class);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned wait_cycles;
    byte_bus.valid      = 1'b0;
    byte_bus.text_byte  = 8'h00;
    byte_bus.final_byte = 1'b0;
    burst_left      = 0;
    bytes_sent      = 0;
    files_sent      = 0;
    results_checked = 0;
    failures        = 0;
    class_seen      = '{0, 0, 0, 0, 0};
    clear_file_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      send_byte(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].cls);
    end

    // Random files; part way through, one-byte files are pushed into a long hold-off.
    while (bytes_sent < RANDOM_BYTES + $size(DIRECTED_ROWS)) begin
      if (!hold_req && bytes_sent >= RANDOM_BYTES / 2) begin
        hold_req <= 1'b1;
        repeat (HOLD_FILES) begin
          file_bytes.delete();
          append_byte(8'($urandom_range(0, 255)));
          send_file();
        end
      end
      build_random_file();
      send_file();
    end
    byte_bus.valid <= 1'b0;

    // Let the outstanding classes drain, then watch a little longer for strays.
    wait_cycles = 0;
    while (expected_classes.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_classes.size() != 0) begin
      $error("encoding_class: %0d expected results never arrived", expected_classes.size());
      failures += expected_classes.size();
    end

    $display("Run covered %0d bytes in %0d files, including a long receiver hold-off.",
             bytes_sent, files_sent);
    $display("Classes checked: utf8 %0d, utf8 with mark %0d, utf16le %0d, utf16be %0d, ansi %0d.",
             class_seen[CLASS_UTF8], class_seen[CLASS_UTF8_BOM], class_seen[CLASS_UTF16LE],
             class_seen[CLASS_UTF16BE], class_seen[CLASS_ANSI]);
    if (failures == 0) begin
      $display("text_encoding_detector test passed");
    end else begin
      $display("text_encoding_detector test failed");
    end
    $finish;
  end

  // Ends a hung run.
  initial begin : watchdog
    #3_000_000;
    $display("text_encoding_detector test failed");
    $finish;
  end

endmodule

// ===== text_encoding_detector.f =====
+incdir+hw/rtl
hw/rtl/ted_pkg.sv
hw/rtl/ted_byte_if.sv
hw/rtl/ted_class_if.sv
hw/rtl/ted_utf8.sv
hw/rtl/ted_stats.sv
hw/rtl/ted_classify.sv
hw/rtl/text_encoding_detector.sv
tb/sv/text_encoding_detector_tb.sv
